// File: rtl/core/vsa_pkg.sv
// shared codes and controller/datapath interface types for the voice slot allocator
package vsa_pkg;

  localparam logic [1:0] OP_PLAY    = 2'd0;
  localparam logic [1:0] OP_STOP    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [1:0] STRAT_STEAL = 2'd0;
  localparam logic [1:0] STRAT_CHOKE = 2'd1;
  localparam logic [1:0] STRAT_COPE  = 2'd2;

  localparam int SLOT_CAP = 16;
  localparam logic [4:0] VOICES_RESET = 5'd16;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_none;
    logic step_ok;
    logic at_last;
    logic finish_ok;
  } sts_t;

endpackage

// File: rtl/core/voice_slot_allocator.sv
// voice slot allocator top level: controller and datapath
// the last word of an item is pushed after the scan of the slot table has passed n slots, n being
// the effective voices_in_use (1..DEPTH, at most 16); the scan takes one slot per clock unless an
// advance grant waits on the output word register; a new item is accepted only in idle, and an
// unused operation returns to idle with no output word; each grant of an advance beyond the first
// waits for the output word register to drain; synchronous reset clears the slot table, all slots
// free, and sets voices_in_use to 16; no clearing pass follows
module voice_slot_allocator #(
  parameter int NUM_VOICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [1:0]  strategy,
  input  logic [7:0]  group_key,
  input  logic [2:0]  voice_kind,
  input  logic [23:0] duration_samples,
  input  logic [15:0] sample_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  slot,
  output logic        accepted,
  output logic [4:0]  cut_count,
  output logic [2:0]  slot_kind,
  output logic [15:0] render_samples,
  output logic        last
);

  localparam int DEPTH = (NUM_VOICES < vsa_pkg::SLOT_CAP) ? NUM_VOICES : vsa_pkg::SLOT_CAP;

  vsa_pkg::cmd_t cmd;
  vsa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  vsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsa_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .operation        (operation),
    .strategy         (strategy),
    .group_key        (group_key),
    .voice_kind       (voice_kind),
    .duration_samples (duration_samples),
    .sample_count     (sample_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slot             (slot),
    .accepted         (accepted),
    .cut_count        (cut_count),
    .slot_kind        (slot_kind),
    .render_samples   (render_samples),
    .last             (last)
  );

endmodule

// File: rtl/core/vsa_ctrl.sv
// controller state machine: accept, slot scan, result push
module vsa_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  vsa_pkg::sts_t sts,
  output vsa_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.op_none) begin
          state_next = ST_IDLE;
        end else if (sts.step_ok) begin
          cmd.step = 1'b1;
          if (sts.at_last) state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.finish_ok) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/vsa_datapath.sv
// slot table, scan registers, grant hold and output word register
module vsa_datapath #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic [4:0]   cfg_data,
  input  logic [1:0]   operation,
  input  logic [1:0]   strategy,
  input  logic [7:0]   group_key,
  input  logic [2:0]   voice_kind,
  input  logic [23:0]  duration_samples,
  input  logic [15:0]  sample_count,
  input  vsa_pkg::cmd_t cmd,
  output vsa_pkg::sts_t sts,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [3:0]   slot,
  output logic         accepted,
  output logic [4:0]   cut_count,
  output logic [2:0]   slot_kind,
  output logic [15:0]  render_samples,
  output logic         last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0] DEPTH_W = 5'(DEPTH);

  logic [7:0]  slot_key       [DEPTH];
  logic [23:0] slot_remaining [DEPTH];
  logic [2:0]  slot_type      [DEPTH];

  logic [4:0]  voices_in_use;

  logic [1:0]  cur_op;
  logic [1:0]  cur_strat;
  logic [7:0]  cur_key;
  logic [2:0]  cur_kind;
  logic [23:0] cur_dur;
  logic [15:0] cur_cnt;

  logic [IW-1:0] idx;
  logic [IW-1:0] pick;
  logic [23:0]   best;
  logic          locked;
  logic          found;
  logic [4:0]    cut;

  logic          held_valid;
  logic [IW-1:0] held_slot;
  logic [2:0]    held_kind;
  logic [15:0]   held_rend;

  logic [4:0]    n_eff;
  logic [IW-1:0] last_idx;
  logic [23:0]   rem;
  logic          keyhit;
  logic          active;
  logic [15:0]   grant;
  logic [23:0]   eff;
  logic          out_free;
  logic          play_ok;
  logic          rem_wr;
  logic [23:0]   rem_wr_val;
  logic          adv_grant;

  always_comb begin
    if (voices_in_use == 5'd0) n_eff = 5'd1;
    else if (voices_in_use > DEPTH_W) n_eff = DEPTH_W;
    else n_eff = voices_in_use;
  end

  assign last_idx = IW'(n_eff - 5'd1);
  assign rem      = slot_remaining[idx];
  assign keyhit   = (slot_key[idx] == cur_key);
  assign active   = (rem != 24'd0);
  assign grant    = (rem < {8'd0, cur_cnt}) ? rem[15:0] : cur_cnt;
  assign eff      = keyhit ? 24'd0 : rem;
  assign out_free = !out_valid || out_ready;
  assign adv_grant = (cur_op == vsa_pkg::OP_ADVANCE) && active;
  assign play_ok  = (cur_strat inside {vsa_pkg::STRAT_STEAL, vsa_pkg::STRAT_CHOKE}) ||
                    ((cur_strat == vsa_pkg::STRAT_COPE) && found);

  assign sts.op_none   = !(cur_op inside {vsa_pkg::OP_PLAY, vsa_pkg::OP_STOP,
                                          vsa_pkg::OP_ADVANCE});
  assign sts.step_ok   = !(adv_grant && held_valid && !out_free);
  assign sts.at_last   = (idx == last_idx);
  assign sts.finish_ok = out_free;

  always_comb begin
    rem_wr     = 1'b0;
    rem_wr_val = 24'd0;
    case (cur_op)
      vsa_pkg::OP_PLAY: begin
        rem_wr = (cur_strat == vsa_pkg::STRAT_CHOKE) && keyhit;
      end
      vsa_pkg::OP_STOP: begin
        rem_wr = keyhit && active;
      end
      vsa_pkg::OP_ADVANCE: begin
        rem_wr     = active;
        rem_wr_val = rem - {8'd0, grant};
      end
      default: rem_wr = 1'b0;
    endcase
  end

  // slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_key[i]       <= 8'd0;
        slot_remaining[i] <= 24'd0;
        slot_type[i]      <= 3'd0;
      end
    end else if (cmd.step && rem_wr) begin
      slot_remaining[idx] <= rem_wr_val;
    end else if (cmd.finish && (cur_op == vsa_pkg::OP_PLAY) && play_ok) begin
      slot_key[pick]       <= cur_key;
      slot_type[pick]      <= cur_kind;
      slot_remaining[pick] <= cur_dur;
    end
  end

  // scan registers and input word
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_op    <= operation;
      cur_strat <= strategy;
      cur_key   <= group_key;
      cur_kind  <= voice_kind;
      cur_dur   <= duration_samples;
      cur_cnt   <= sample_count;
      idx       <= '0;
      pick      <= '0;
      best      <= 24'd0;
      locked    <= 1'b0;
      found     <= 1'b0;
      cut       <= 5'd0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
      case (cur_op)
        vsa_pkg::OP_PLAY: begin
          case (cur_strat)
            vsa_pkg::STRAT_STEAL: begin
              if (!locked) begin
                if (!active) begin
                  pick   <= idx;
                  locked <= 1'b1;
                end else if ((idx == '0) || (rem < best)) begin
                  pick <= idx;
                  best <= rem;
                end
              end
            end
            vsa_pkg::STRAT_CHOKE: begin
              if (keyhit && active) cut <= cut + 5'd1;
              if ((idx == '0) || (eff == 24'd0) || (eff < best)) begin
                pick <= idx;
                best <= eff;
              end
            end
            vsa_pkg::STRAT_COPE: begin
              if (!found && !active) begin
                pick  <= idx;
                found <= 1'b1;
              end
            end
            default: found <= 1'b0;
          endcase
        end
        vsa_pkg::OP_STOP: begin
          if (keyhit && active) cut <= cut + 5'd1;
        end
        default: cut <= cut;
      endcase
    end
  end

  // grant hold, output word register, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      held_valid    <= 1'b0;
      voices_in_use <= vsa_pkg::VOICES_RESET;
    end else begin
      if (cfg_valid) voices_in_use <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.start) held_valid <= 1'b0;
      if (cmd.step && adv_grant) begin
        held_valid <= 1'b1;
        held_slot  <= idx;
        held_kind  <= slot_type[idx];
        held_rend  <= grant;
        if (held_valid) begin
          out_valid      <= 1'b1;
          slot           <= 4'(held_slot);
          accepted       <= 1'b1;
          cut_count      <= 5'd0;
          slot_kind      <= held_kind;
          render_samples <= held_rend;
          last           <= 1'b0;
        end
      end
      if (cmd.finish) begin
        out_valid      <= 1'b1;
        last           <= 1'b1;
        slot           <= 4'd0;
        accepted       <= 1'b0;
        cut_count      <= cut;
        slot_kind      <= 3'd0;
        render_samples <= 16'd0;
        case (cur_op)
          vsa_pkg::OP_PLAY: begin
            if (play_ok) begin
              slot     <= 4'(pick);
              accepted <= 1'b1;
            end
          end
          vsa_pkg::OP_ADVANCE: begin
            cut_count <= 5'd0;
            if (held_valid) begin
              slot           <= 4'(held_slot);
              accepted       <= 1'b1;
              slot_kind      <= held_kind;
              render_samples <= held_rend;
            end
          end
          default: accepted <= 1'b0;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/vsa_checker.sv
// port-level checks on the voice slot allocator and their bind
module vsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  slot,
  input logic        accepted,
  input logic [4:0]  cut_count,
  input logic [2:0]  slot_kind,
  input logic [15:0] render_samples,
  input logic        last
);

  // busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(last) &&
      $stable(render_samples) && $stable(accepted))
    else $error("stalled output word changed");

  // words before the last one are render grants
  a_grant_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> accepted && (cut_count == 5'd0))
    else $error("non-final word is not a grant");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> (slot == 4'd0) && (slot_kind == 3'd0) &&
      (render_samples == 16'd0) && last)
    else $error("refused word carries slot data");

endmodule

bind voice_slot_allocator vsa_checker u_vsa_checker (.*);
